@@ hw/rtl/pbu_pkg.sv @@
// Shared types, constants and unpacking functions of the packed block unpacker.
package pbu_pkg;

    localparam int BLOCK_VALUES      = 64;
    localparam int MAX_PAYLOAD_BYTES = 128;
    localparam int STORE_DEPTH       = 2 * MAX_PAYLOAD_BYTES;
    localparam int POS_W             = $clog2(BLOCK_VALUES);
    localparam int SADDR_W           = $clog2(MAX_PAYLOAD_BYTES);

    localparam logic [4:0] CODE_MAX  = 5'd16;

    typedef struct packed {
        logic [4:0]  code;
        logic [15:0] ref_value;
        logic        bank;
    } t_job;

    // Codes 7 and 9 decode as 8 and 10; everything from 11 up reads 16-bit pairs.
    function automatic logic [4:0] norm_code(input logic [4:0] c);
        logic [4:0] r;
        r = c;
        if (r > CODE_MAX) r = CODE_MAX;
        if (r == 5'd7) r = 5'd8;
        if (r == 5'd9) r = 5'd10;
        if (r >= 5'd11) r = CODE_MAX;
        return r;
    endfunction

    function automatic logic [7:0] payload_len(input logic [4:0] c);
        logic [7:0] n;
        case (c)
            5'd0:    n = 8'd0;
            5'd1:    n = 8'd8;
            5'd2:    n = 8'd16;
            5'd3:    n = 8'd24;
            5'd4:    n = 8'd32;
            5'd5:    n = 8'd40;
            5'd6:    n = 8'd48;
            5'd8:    n = 8'd64;
            5'd10:   n = 8'd80;
            default: n = 8'd128;
        endcase
        return n;
    endfunction

    function automatic logic [SADDR_W-1:0] col(input logic [3:0] ri, input logic [2:0] l);
        return {ri, l};
    endfunction

    // Store address of the k-th byte that the value at position pos needs.
    function automatic logic [SADDR_W-1:0] src_addr(input logic [4:0] c,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [1:0] k);
        logic [2:0] l;
        logic [2:0] r;
        logic [SADDR_W-1:0] a;
        l = pos[2:0];
        r = pos[5:3];
        a = col(4'd0, l);
        case (c)
            5'd2: a = col({3'd0, r[2]}, l);
            5'd3: begin
                if (k != 2'd0)   a = col(4'd2, l);
                else if (r < 3'd3) a = col(4'd0, l);
                else if (r < 3'd6) a = col(4'd1, l);
                else             a = col(4'd2, l);
            end
            5'd4: a = col({2'd0, r[2:1]}, l);
            5'd5: begin
                if (r < 3'd5)       a = col({1'b0, r}, l);
                else if (r == 3'd5) a = (k == 2'd0) ? col(4'd0, l) : col(4'd3, l);
                else if (r == 3'd6) a = (k == 2'd0) ? col(4'd1, l) : col(4'd4, l);
                else                a = col(4'd2 + {2'd0, k}, l);
            end
            5'd6: begin
                if (r < 3'd6)       a = col({1'b0, r}, l);
                else if (r == 3'd6) a = col({2'd0, k}, l);
                else                a = col(4'd3 + {2'd0, k}, l);
            end
            5'd8: a = {1'b0, pos};
            5'd10: begin
                if (k == 2'd0) a = (r < 3'd4) ? col({1'b0, r}, l) : col({1'b0, r} + 4'd1, l);
                else           a = (r < 3'd4) ? col(4'd4, l) : col(4'd9, l);
            end
            5'd16: a = {pos, k[0]};
            default: a = col(4'd0, l);
        endcase
        return a;
    endfunction

    // Raw unpacked value from the up to three fetched bytes.
    function automatic logic [15:0] unpack_raw(input logic [4:0] c,
                                               input logic [POS_W-1:0] pos,
                                               input logic [7:0] b0,
                                               input logic [7:0] b1,
                                               input logic [7:0] b2);
        logic [2:0] r;
        logic [7:0] sh;
        logic [15:0] v;
        r = pos[5:3];
        sh = 8'd0;
        v = 16'd0;
        case (c)
            5'd1: begin
                sh = b0 >> r;
                v = {15'd0, sh[0]};
            end
            5'd2: begin
                sh = b0 >> {r[1:0], 1'b0};
                v = {14'd0, sh[1:0]};
            end
            5'd3: begin
                case (r)
                    3'd2:    v = {13'd0, b1[6], b0[7:6]};
                    3'd5:    v = {13'd0, b1[7], b0[7:6]};
                    3'd1, 3'd4, 3'd7: v = {13'd0, b0[5:3]};
                    default: v = {13'd0, b0[2:0]};
                endcase
            end
            5'd4: v = r[0] ? {12'd0, b0[7:4]} : {12'd0, b0[3:0]};
            5'd5: begin
                if (r < 3'd5)       v = {11'd0, b0[4:0]};
                else if (r == 3'd7) v = {11'd0, b2[7], b1[7], b0[7:5]};
                else                v = {11'd0, b1[6:5], b0[7:5]};
            end
            5'd6: begin
                if (r < 3'd6) v = {10'd0, b0[5:0]};
                else          v = {10'd0, b2[7:6], b1[7:6], b0[7:6]};
            end
            5'd8: v = {8'd0, b0};
            5'd10: begin
                sh = b1 >> {r[1:0], 1'b0};
                v = {6'd0, sh[1:0], b0};
            end
            5'd16: v = {b1, b0};
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/packed_block_unpacker.sv @@
// Top level of the packed block unpacker: bit-packed 64-value blocks to a value stream.
//
// Input stream: one request per byte or command. s_tuser = 1 starts a block with the
// code and reference given in s_tdata; s_tuser = 0 carries a header or payload byte.
// With the inline header register set, an idle block expects a two-byte header first.
// Output stream: one request per decoded value, with its position; m_tlast marks the
// 64th value of each block.
// Payload bytes are taken one per cycle while s_tready is high, into one of two 128-byte
// store banks. A block whose payload is complete is queued for the back end. For each
// value the back end makes three reads of the single store read port and then combines
// the bytes. While two blocks are outstanding s_tready is low until the older one has
// drained.
// A stall on the output holds the value register and halts fetching; input continues
// into the free bank. Reset clears the header state, the output valid flag, the job
// queue and block count; the store needs no clearing: only current-block bytes are read.
module packed_block_unpacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], width_code[12:8], ref_value[28:13]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value[15:0], position[21:16]
    output logic        m_tlast
);

    localparam int AW = $clog2(pbu_pkg::STORE_DEPTH);

    logic                      w_accept;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [7:0]                w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [7:0]                w_rdata;
    logic                      w_push;
    logic                      w_pop;
    logic                      w_empty;
    logic                      w_done;
    pbu_pkg::t_job             w_job_in;
    pbu_pkg::t_job             w_job_out;
    logic [15:0]               w_value;
    logic [pbu_pkg::POS_W-1:0] w_pos;

    assign w_accept = s_tvalid && s_tready;

    pbu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (w_accept),
        .i_cmd      (s_tuser),
        .i_byte     (s_tdata[7:0]),
        .i_code     (s_tdata[12:8]),
        .i_ref      (s_tdata[28:13]),
        .i_done     (w_done),
        .o_ready    (s_tready),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    pbu_ram #(
        .WIDTH(8),
        .DEPTH(pbu_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    pbu_job_fifo u_jobs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_job  (w_job_out)
    );

    pbu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata),
        .o_done    (w_done),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_value   (w_value),
        .o_position(w_pos),
        .o_last    (m_tlast)
    );

    assign m_tdata = {2'b00, w_pos, w_value};

endmodule

@@ hw/rtl/pbu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pbu_job_fifo.sv @@
// Two-entry queue of completed block descriptors between front and back.
module pbu_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbu_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output pbu_pkg::t_job o_job
);

    pbu_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

@@ hw/rtl/pbu_front.sv @@
// Front end: parses commands and headers, stores payload bytes, issues block jobs.
module pbu_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                i_accept,
    input  logic                                i_cmd,
    input  logic [7:0]                          i_byte,
    input  logic [4:0]                          i_code,
    input  logic [15:0]                         i_ref,
    input  logic                                i_done,
    output logic                                o_ready,
    output logic                                o_we,
    output logic [$clog2(pbu_pkg::STORE_DEPTH)-1:0] o_waddr,
    output logic [7:0]                          o_wdata,
    output logic                                o_push,
    output pbu_pkg::t_job                       o_job
);

    typedef enum logic [1:0] {ST_IDLE, ST_HDR2, ST_COLLECT} t_state;

    t_state      r_state, n_state;
    logic        r_inline;
    logic [4:0]  r_code, n_code;
    logic [15:0] r_ref, n_ref;
    logic [7:0]  r_count, n_count;
    logic        r_bank;
    logic [1:0]  r_outst;
    logic [7:0]  w_cnt_inc;

    assign w_cnt_inc = r_count + 8'd1;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_ref   = r_ref;
        n_count = r_count;
        o_push  = 1'b0;
        o_we    = 1'b0;
        if (i_accept) begin
            if (i_cmd || r_state == ST_HDR2) begin
                if (i_cmd) begin
                    n_code = i_code;
                    n_ref  = i_ref;
                end else begin
                    n_ref = r_ref | {8'd0, i_byte};
                end
                n_count = 8'd0;
                n_state = ST_COLLECT;
                if (pbu_pkg::payload_len(pbu_pkg::norm_code(n_code)) == 8'd0) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end else if (r_state == ST_COLLECT) begin
                o_we    = 1'b1;
                n_count = w_cnt_inc;
                if (w_cnt_inc >= pbu_pkg::payload_len(pbu_pkg::norm_code(r_code))) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                    n_count = 8'd0;
                end
            end else if (r_inline) begin
                n_code  = {1'b0, i_byte[7:4]};
                n_ref   = {4'd0, i_byte[3:0], 8'd0};
                n_state = ST_HDR2;
            end else begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_inline <= 1'b0;
            r_code   <= 5'd0;
            r_ref    <= 16'd0;
            r_count  <= 8'd0;
            r_bank   <= 1'b0;
            r_outst  <= 2'd0;
        end else begin
            if (i_cfg_we) r_inline <= i_cfg_wdata;
            r_state <= n_state;
            r_code  <= n_code;
            r_ref   <= n_ref;
            r_count <= n_count;
            if (o_push) r_bank <= ~r_bank;
            r_outst <= r_outst + {1'b0, o_push} - {1'b0, i_done};
        end
    end

    // Two store banks: while both hold unfinished blocks, no byte may be taken.
    assign o_ready       = (r_outst != 2'd2);
    assign o_waddr       = {r_bank, r_count[pbu_pkg::SADDR_W-1:0]};
    assign o_wdata       = i_byte;
    assign o_job.code    = pbu_pkg::norm_code(n_code);
    assign o_job.ref_value = n_ref;
    assign o_job.bank    = r_bank;

endmodule

@@ hw/rtl/pbu_back.sv @@
// Back end: fetches bytes per value from the store and emits the 64 decoded values.
module pbu_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_empty,
    input  pbu_pkg::t_job                           i_job,
    output logic                                    o_pop,
    output logic [$clog2(pbu_pkg::STORE_DEPTH)-1:0] o_raddr,
    input  logic [7:0]                              i_rdata,
    output logic                                    o_done,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [15:0]                             o_value,
    output logic [pbu_pkg::POS_W-1:0]               o_position,
    output logic                                    o_last
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                    r_state;
    pbu_pkg::t_job             r_job;
    logic [pbu_pkg::POS_W-1:0] r_pos;
    logic [1:0]                r_ph;
    logic [7:0]                r_b0;
    logic [7:0]                r_b1;
    logic                      r_valid;
    logic [15:0]               r_value;
    logic [pbu_pkg::POS_W-1:0] r_opos;
    logic                      r_last;
    logic                      w_load;
    logic [15:0]               w_value;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    // In the final phase the address stays on the third byte, so a stall keeps it on the port.
    assign o_raddr = {r_job.bank,
                      pbu_pkg::src_addr(r_job.code, r_pos, (r_ph == 2'd3) ? 2'd2 : r_ph)};
    // The third byte is taken straight from the read port in the final phase.
    assign w_value = pbu_pkg::unpack_raw(r_job.code, r_pos, r_b0, r_b1, i_rdata)
                     + r_job.ref_value;
    assign w_load  = (r_state == ST_RUN) && (r_ph == 2'd3) && (!r_valid || i_ready);
    assign o_done  = w_load && (r_pos == pbu_pkg::POS_W'(pbu_pkg::BLOCK_VALUES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_ph    <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready && !w_load) r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_pos   <= '0;
                        r_ph    <= 2'd0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_ph == 2'd1) r_b0 <= i_rdata;
                    if (r_ph == 2'd2) r_b1 <= i_rdata;
                    if (r_ph != 2'd3) begin
                        r_ph <= r_ph + 2'd1;
                    end else if (w_load) begin
                        r_valid <= 1'b1;
                        r_value <= w_value;
                        r_opos  <= r_pos;
                        r_last  <= o_done;
                        r_ph    <= 2'd0;
                        r_pos   <= r_pos + pbu_pkg::POS_W'(1);
                        if (o_done) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_position = r_opos;
    assign o_last     = r_last;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_valid && r_last))
        else $error("finished block did not present its last value");
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_opos == pbu_pkg::POS_W'(pbu_pkg::BLOCK_VALUES - 1)))
        else $error("last flag on a value other than the final one");
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_ph == 2'd0 || r_ph == 2'd3))
        else $error("fetch phase out of step with sequencer state");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_RUN && r_pos == '0 && r_ph == 2'd0))
        else $error("job taken without starting at the first value");

endmodule
